// ----- hw/rtl/bcse_pkg.sv -----
package bcse_pkg;

   // symbols per alignment position: A, C, G, T, deletion
   localparam int NUM_SYM = 5;

   // fraction bits of the base-2 log
   localparam int LOG_FRAC = 24;

   // log2 unit: leading-one stage, normalize stage, one squaring per fraction bit
   localparam int LOG_LAT = LOG_FRAC + 2;

   // entropy in bits, Q24; five symbols stay below 2.33 bits
   localparam int SUM_W = 27;

   localparam int ENT_W      = 17;
   localparam int LN2_W      = 32;
   localparam int PROD_LN_W  = SUM_W + LN2_W;
   localparam int RND_W      = PROD_LN_W + 1;
   localparam int RND_SHIFT  = 40;

   // ln 2 in Q0.32
   localparam logic [LN2_W-1:0] LN2_Q32 = 32'd2977044472;

   // ln 5 in Q1.16
   localparam logic [ENT_W-1:0] ENT_MAX = 17'd105478;

endpackage

// ----- hw/rtl/bcse_if.sv -----
interface bcse_req_if #(
   parameter int CNT_W = 16
);
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] count_a;
   logic [CNT_W-1:0] count_c;
   logic [CNT_W-1:0] count_g;
   logic [CNT_W-1:0] count_t;
   logic [CNT_W-1:0] count_del;

   modport source (
      output valid, count_a, count_c, count_g, count_t, count_del,
      input  ready
   );
   modport sink (
      input  valid, count_a, count_c, count_g, count_t, count_del,
      output ready
   );
endinterface

interface bcse_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] entropy_nats;

   modport source (
      output valid, entropy_nats,
      input  ready
   );
   modport sink (
      input  valid, entropy_nats,
      output ready
   );
endinterface

// ----- hw/rtl/bcse_delay.sv -----
module bcse_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         d_vld,
   input  logic [W-1:0] d_data,
   output logic         q_vld,
   output logic [W-1:0] q_data
);
   logic         vld_ff  [0:DEPTH-1];
   logic [W-1:0] data_ff [0:DEPTH-1];

   // valid lane: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= d_vld;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= d_data;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign q_vld  = vld_ff[DEPTH-1];
   assign q_data = data_ff[DEPTH-1];

endmodule

// ----- hw/rtl/bcse_log2.sv -----
module bcse_log2 #(
   parameter  int W  = 19,
   localparam int LW = $clog2(W) + bcse_pkg::LOG_FRAC
) (
   input  logic          clock,
   input  logic          en,
   input  logic [W-1:0]  x,
   output logic [LW-1:0] log_q
);
   import bcse_pkg::*;

   localparam int MSB_W = $clog2(W);
   localparam int SH_W  = W + 31;

   logic [W-1:0]     x_ff;
   logic [MSB_W-1:0] msb_ff;
   logic [MSB_W-1:0] msb_in;
   logic [SH_W-1:0]  shifted;
   logic [31:0]      y_ff [0:LOG_FRAC];
   logic [LW-1:0]    r_ff [0:LOG_FRAC];

   // leading one
   always_comb begin
      msb_in = '0;
      for (int i = 0; i < W; i++) begin
         if (x[i]) begin
            msb_in = MSB_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x;
         msb_ff <= msb_in;
      end
   end

   // mantissa in Q1.31
   assign shifted = {x_ff, 31'b0} >> msb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0] <= shifted[31:0];
         r_ff[0] <= {msb_ff, LOG_FRAC'(0)};
      end
   end

   // one fraction bit per stage: square, renormalize
   for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
      logic [63:0]   sq;
      logic [32:0]   t;
      logic [31:0]   y_in;
      logic [LW-1:0] r_in;

      assign sq = 64'(y_ff[k]) * 64'(y_ff[k]);
      assign t  = sq[63:31];

      always_comb begin
         if (t[32]) begin
            y_in = t[32:1];
            r_in = r_ff[k] | (LW'(1) << (LOG_FRAC - 1 - k));
         end else begin
            y_in = t[31:0];
            r_in = r_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            y_ff[k+1] <= y_in;
            r_ff[k+1] <= r_in;
         end
      end
   end

   assign log_q = r_ff[LOG_FRAC];

endmodule

// ----- hw/rtl/bcse_div.sv -----
module bcse_div #(
   parameter int N_W = 45,
   parameter int D_W = 19,
   parameter int Q_W = 29
) (
   input  logic           clock,
   input  logic           en,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic [Q_W-1:0] quo
);
   // quotient is known to fit Q_W bits, so the top bits start as the remainder
   logic [D_W-1:0] rem_ff [0:Q_W-1];
   logic [Q_W-1:0] lo_ff  [0:Q_W-1];
   logic [Q_W-1:0] q_ff   [0:Q_W-1];
   logic [D_W-1:0] d_ff   [0:Q_W-1];

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [D_W-1:0] rem_s;
      logic [Q_W-1:0] lo_s;
      logic [Q_W-1:0] q_s;
      logic [D_W-1:0] d_s;
      logic [D_W:0]   trial;
      logic           ge;
      logic [D_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_s = D_W'(num[N_W-1:Q_W]);
         assign lo_s  = num[Q_W-1:0];
         assign q_s   = '0;
         assign d_s   = den;
      end else begin : g_next
         assign rem_s = rem_ff[k-1];
         assign lo_s  = lo_ff[k-1];
         assign q_s   = q_ff[k-1];
         assign d_s   = d_ff[k-1];
      end

      assign trial  = {rem_s, lo_s[Q_W-1]};
      assign ge     = (trial >= {1'b0, d_s});
      assign rem_in = ge ? D_W'(trial - {1'b0, d_s}) : trial[D_W-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            lo_ff[k]  <= lo_s << 1;
            q_ff[k]   <= {q_s[Q_W-2:0], ge};
            d_ff[k]   <= d_s;
         end
      end
   end

   assign quo = q_ff[Q_W-1];

endmodule

// ----- hw/rtl/base_count_shannon_entropy.sv -----
// Channel   Dir  Handshake                  Word
// req_ch    in   req_ch.valid/req_ch.ready  count_a, count_c, count_g, count_t, count_del
// rsp_ch    out  rsp_ch.valid/rsp_ch.ready  entropy_nats (Q1.16 nats)
//
// One word enters per cycle while rsp_ch does not stall. The depth is set by
// the log2 units (one squaring per fraction bit) and the restoring dividers
// (one quotient bit per stage). Reset is synchronous and clears the valid
// bits only.
// A stall on rsp_ch freezes every stage at once; req_ch.ready drops in the
// same cycle, so nothing is lost or repeated.
module base_count_shannon_entropy #(
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   bcse_req_if.sink     req_ch,
   bcse_rsp_if.source   rsp_ch
);
   import bcse_pkg::*;

   localparam int CB     = COUNT_BITS;
   localparam int TOT_W  = CB + 3;
   localparam int LT_W   = $clog2(TOT_W) + LOG_FRAC;
   localparam int LC_W   = $clog2(CB) + LOG_FRAC;
   localparam int PROD_W = CB + LT_W;
   localparam int SB_W   = NUM_SYM * CB + TOT_W + 1;
   localparam int QS_W   = LT_W + 3;

   // pipeline advance: output register empty or being taken
   logic adv;

   // stage 0: input capture
   logic          v0_ff;
   logic [CB-1:0] cnt0_ff [NUM_SYM];

   // stage 1: total and largest count
   logic             v1_ff;
   logic [CB-1:0]    cnt1_ff [NUM_SYM];
   logic [TOT_W-1:0] tot1_ff;
   logic [TOT_W-1:0] tot1_in;
   logic [CB-1:0]    max1_ff;
   logic [CB-1:0]    max1_in;
   logic             solo1;

   // log2 stages
   logic [LC_W-1:0]  lc [NUM_SYM];
   logic [LT_W-1:0]  lt;
   logic [SB_W-1:0]  sb_d;
   logic [SB_W-1:0]  sb_q;
   logic             sb_vld;

   // stage 2: log differences
   logic             v2_ff;
   logic [LT_W-1:0]  diff2_ff [NUM_SYM];
   logic [CB-1:0]    cnt2_ff  [NUM_SYM];
   logic [TOT_W-1:0] tot2_ff;
   logic             solo2_ff;

   // stage 3: c * L
   logic              v3_ff;
   logic [PROD_W-1:0] prod3_ff [NUM_SYM];
   logic [TOT_W-1:0]  tot3_ff;
   logic              solo3_ff;

   // divider stages
   logic [LT_W-1:0] quo [NUM_SYM];
   logic            dv_vld;
   logic            dv_solo;

   // stage 4: sum of terms, bits Q24
   logic             v4_ff;
   logic [SUM_W-1:0] sum4_ff;
   logic [QS_W-1:0]  qsum;
   logic             solo4_ff;

   // stage 5: times ln 2
   logic                 v5_ff;
   logic [PROD_LN_W-1:0] pl5_ff;
   logic                 solo5_ff;

   // output register
   logic             rsp_valid_ff;
   logic [ENT_W-1:0] ent_ff;
   logic [ENT_W-1:0] ent_in;
   logic [RND_W-1:0] rnd;
   logic [RND_W-RND_SHIFT-1:0] nats;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= req_ch.valid;
         v1_ff        <= v0_ff;
         v2_ff        <= sb_vld;
         v3_ff        <= v2_ff;
         v4_ff        <= dv_vld;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   // stage 0: hold the word, keep the low COUNT_BITS of each count
   always_ff @(posedge clock) begin
      if (adv) begin
         cnt0_ff[0] <= CB'(req_ch.count_a);
         cnt0_ff[1] <= CB'(req_ch.count_c);
         cnt0_ff[2] <= CB'(req_ch.count_g);
         cnt0_ff[3] <= CB'(req_ch.count_t);
         cnt0_ff[4] <= CB'(req_ch.count_del);
      end
   end

   // stage 1: full-width total, no wrap
   always_comb begin
      tot1_in = '0;
      max1_in = '0;
      for (int i = 0; i < NUM_SYM; i++) begin
         tot1_in = tot1_in + TOT_W'(cnt0_ff[i]);
         if (cnt0_ff[i] > max1_in) begin
            max1_in = cnt0_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cnt1_ff <= cnt0_ff;
         tot1_ff <= tot1_in;
         max1_ff <= max1_in;
      end
   end

   // one symbol only, or nothing at all: entropy is exactly zero
   assign solo1 = (TOT_W'(max1_ff) == tot1_ff);

   for (genvar i = 0; i < NUM_SYM; i++) begin : g_lc
      bcse_log2 #(.W(CB)) u_log_c (
         .clock (clock),
         .en    (adv),
         .x     (cnt1_ff[i]),
         .log_q (lc[i])
      );
   end

   bcse_log2 #(.W(TOT_W)) u_log_t (
      .clock (clock),
      .en    (adv),
      .x     (tot1_ff),
      .log_q (lt)
   );

   // carry counts, total and the zero flag alongside the log units
   always_comb begin
      sb_d = '0;
      for (int i = 0; i < NUM_SYM; i++) begin
         sb_d[i*CB +: CB] = cnt1_ff[i];
      end
      sb_d[NUM_SYM*CB +: TOT_W] = tot1_ff;
      sb_d[SB_W-1]              = solo1;
   end

   bcse_delay #(.W(SB_W), .DEPTH(LOG_LAT)) u_log_side (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .d_vld  (v1_ff),
      .d_data (sb_d),
      .q_vld  (sb_vld),
      .q_data (sb_q)
   );

   // stage 2: L = log2(T) - log2(c), floored at zero; drop empty symbols
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NUM_SYM; i++) begin
            cnt2_ff[i] <= sb_q[i*CB +: CB];
            if (sb_q[i*CB +: CB] == '0 || lt <= LT_W'(lc[i])) begin
               diff2_ff[i] <= '0;
            end else begin
               diff2_ff[i] <= lt - LT_W'(lc[i]);
            end
         end
         tot2_ff  <= sb_q[NUM_SYM*CB +: TOT_W];
         solo2_ff <= sb_q[SB_W-1];
      end
   end

   // stage 3: weight each log by its count
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NUM_SYM; i++) begin
            prod3_ff[i] <= PROD_W'(cnt2_ff[i]) * PROD_W'(diff2_ff[i]);
         end
         tot3_ff  <= tot2_ff;
         solo3_ff <= solo2_ff;
      end
   end

   // divide each term by the total, one quotient bit per stage
   for (genvar i = 0; i < NUM_SYM; i++) begin : g_div
      bcse_div #(.N_W(PROD_W), .D_W(TOT_W), .Q_W(LT_W)) u_div (
         .clock (clock),
         .en    (adv),
         .num   (prod3_ff[i]),
         .den   (tot3_ff),
         .quo   (quo[i])
      );
   end

   bcse_delay #(.W(1), .DEPTH(LT_W)) u_div_side (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .d_vld  (v3_ff),
      .d_data (solo3_ff),
      .q_vld  (dv_vld),
      .q_data (dv_solo)
   );

   // stage 4: sum of terms; a real entropy stays well inside SUM_W
   always_comb begin
      qsum = '0;
      for (int i = 0; i < NUM_SYM; i++) begin
         qsum = qsum + QS_W'(quo[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum4_ff  <= qsum[SUM_W-1:0];
         solo4_ff <= dv_solo;
      end
   end

   // stage 5: bits to nats
   always_ff @(posedge clock) begin
      if (adv) begin
         pl5_ff   <= PROD_LN_W'(sum4_ff) * PROD_LN_W'(LN2_Q32);
         solo5_ff <= solo4_ff;
      end
   end

   // round half up to Q16, clamp at ln 5, force zero for a single symbol
   assign rnd  = RND_W'(pl5_ff) + (RND_W'(1) << (RND_SHIFT - 1));
   assign nats = rnd[RND_W-1:RND_SHIFT];

   always_comb begin
      if (solo5_ff) begin
         ent_in = '0;
      end else if (nats > (RND_W-RND_SHIFT)'(ENT_MAX)) begin
         ent_in = ENT_MAX;
      end else begin
         ent_in = nats[ENT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ent_ff <= ent_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.entropy_nats = ent_ff;

   // a single-symbol word must come out as zero
   a_solo_zero: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && solo5_ff && adv) |=> (rsp_ch.entropy_nats == '0))
      else $error("single-symbol word gave nonzero entropy");

   // clamp holds at the output
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.entropy_nats <= ENT_MAX))
      else $error("entropy above ln 5");

   // a stall freezes the valid bits inside the pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(v1_ff) && $stable(v3_ff) && $stable(v5_ff)))
      else $error("pipeline moved during a stall");

endmodule

// ----- tb/base_count_shannon_entropy_tb.sv -----
`timescale 1ns / 1ps

module base_count_shannon_entropy_tb;
   import bcse_pkg::*;

   localparam int CNT_W     = 16;
   localparam int LATENCY   = 90;
   localparam int CYCLE_MAX = 400000;

   logic clock;
   logic reset;

   bcse_req_if #(.CNT_W(CNT_W)) req_ch ();
   bcse_rsp_if                  rsp_ch ();

   base_count_shannon_entropy #(.COUNT_BITS(CNT_W)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [ENT_W-1:0] entropy_q[$];
   int               n_errors;
   int               cycle_cnt;
   bit               no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // log2 of an integer in Q8.24: top set bit plus repeated squaring
   function automatic logic [63:0] log2_fix(input logic [63:0] x);
      logic [63:0] y;
      logic [63:0] acc;
      int          msb;
      msb = 0;
      for (int k = 0; k < 64; k++) begin
         if (x[k]) msb = k;
      end
      if (msb <= 31) y = x << (31 - msb);
      else y = x >> (msb - 31);
      acc = 64'(msb) << LOG_FRAC;
      for (int k = LOG_FRAC - 1; k >= 0; k--) begin
         y = (y * y) >> 31;
         if (y >= 64'h1_0000_0000) begin
            y = y >> 1;
            acc[k] = 1'b1;
         end
      end
      return acc;
   endfunction

   function automatic logic [ENT_W-1:0] entropy_of(input logic [CNT_W-1:0] cnt[NUM_SYM]);
      logic [63:0] total;
      logic [63:0] maxc;
      logic [63:0] log_total;
      logic [63:0] lc;
      logic [63:0] diff;
      logic [63:0] bits_sum;
      logic [63:0] nats;
      total = 0;
      maxc = 0;
      bits_sum = 0;
      for (int i = 0; i < NUM_SYM; i++) begin
         total += cnt[i];
         if (cnt[i] > maxc) maxc = cnt[i];
      end
      // one symbol only, or nothing at all: exactly zero
      if (maxc == total) return '0;
      log_total = log2_fix(total);
      for (int i = 0; i < NUM_SYM; i++) begin
         if (cnt[i] != 0) begin
            lc = log2_fix(64'(cnt[i]));
            diff = (log_total > lc) ? log_total - lc : 0;
            bits_sum += (64'(cnt[i]) * diff) / total;
         end
      end
      nats = (bits_sum * 64'(LN2_Q32) + (64'd1 << 39)) >> 40;
      if (nats > 64'(ENT_MAX)) nats = 64'(ENT_MAX);
      return nats[ENT_W-1:0];
   endfunction

   // drive one word at the falling edge, hold until taken; drop valid while idling
   task automatic send_counts(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] c,
                              input logic [CNT_W-1:0] g, input logic [CNT_W-1:0] t,
                              input logic [CNT_W-1:0] d);
      logic [CNT_W-1:0] cnt[NUM_SYM];
      while (!no_idle && $urandom_range(99) < 20) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      cnt = '{a, c, g, t, d};
      entropy_q.push_back(entropy_of(cnt));
      req_ch.valid     <= 1'b1;
      req_ch.count_a   <= a;
      req_ch.count_c   <= c;
      req_ch.count_g   <= g;
      req_ch.count_t   <= t;
      req_ch.count_del <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [CNT_W-1:0] rand_count();
      case ($urandom_range(5))
         0: return '0;
         1: return CNT_W'($urandom_range(15));
         2: return '1;
         3: return CNT_W'($urandom_range(65535, 60000));
         default: return CNT_W'($urandom);
      endcase
   endfunction

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (entropy_q.size() != 0) @(negedge clock);
   endtask

   // extremes of every field, single symbol, all zero, even spreads
   task automatic test_directed();
      send_counts(0, 0, 0, 0, 0);
      send_counts('1, 0, 0, 0, 0);
      send_counts(0, '1, 0, 0, 0);
      send_counts(0, 0, '1, 0, 0);
      send_counts(0, 0, 0, '1, 0);
      send_counts(0, 0, 0, 0, '1);
      send_counts(1, 0, 0, 0, 0);
      send_counts(1, 1, 0, 0, 0);
      send_counts(1, 1, 1, 1, 1);
      send_counts('1, '1, '1, '1, '1);
      send_counts('1, '1, 0, 0, 0);
      send_counts(1, '1, 0, 0, 0);
      send_counts('1, 1, 1, 1, 1);
      send_counts(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_counts(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_counts(3, 7, 11, 13, 17);
      send_counts(1000, 1000, 1000, 1000, 999);
      send_counts(0, 0, 0, 0, 1);
      send_counts(2, 0, 0, 0, 2);
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) begin
         send_counts(rand_count(), rand_count(), rand_count(), rand_count(), rand_count());
      end
   endtask

   // consumer side: random stalls, sample at the rising edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= no_idle || ($urandom_range(99) >= 20);
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (entropy_q.size() == 0) begin
            $error("unexpected result entropy_nats=%0d", rsp_ch.entropy_nats);
            n_errors++;
         end else begin
            if (rsp_ch.entropy_nats !== entropy_q[0]) begin
               $error("entropy_nats expected %0d actual %0d", entropy_q[0],
                      rsp_ch.entropy_nats);
               n_errors++;
            end
            void'(entropy_q.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_MAX) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      n_errors         = 0;
      cycle_cnt        = 0;
      no_idle          = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.count_a   = '0;
      req_ch.count_c   = '0;
      req_ch.count_g   = '0;
      req_ch.count_t   = '0;
      req_ch.count_del = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      // hold off until every result is back
      drain();
      test_random(700);
      // full-rate stretch on both sides
      no_idle = 1'b1;
      test_random(300);
      no_idle = 1'b0;
      test_random(530);

      drain();
      repeat (LATENCY) @(negedge clock);
      if (n_errors == 0 && entropy_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/bcse_pkg.sv
hw/rtl/bcse_if.sv
hw/rtl/bcse_delay.sv
hw/rtl/bcse_log2.sv
hw/rtl/bcse_div.sv
hw/rtl/base_count_shannon_entropy.sv
tb/base_count_shannon_entropy_tb.sv
